// File: src/pls_pkg.sv
// pls_pkg: shared types and codes for the positional list store.
// Transfer structs for the request and result channels, the cell control
// struct, request and status codes. No dependencies.
`default_nettype none

package pls_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int CNT_OUT_W    = 7;
  localparam int REQ_W        = 2;
  localparam int ST_W         = 2;
  localparam int CAPACITY_DEF = 64;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pls_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic [ST_W-1:0]          status;
  } pls_out_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } pls_cell_ctl_t;

endpackage

`default_nettype wire

// File: src/positional_list_store.sv
// positional_list_store: ordered list with insert, remove and read by position.
// Top level: request decode, entry count, output register, chain of pls_cell.
// Depends on pls_pkg and pls_cell.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    pls_in_t  (req_type, position, value)
//   out      out  out_valid/out_stall  pls_out_t (read_value, entry_count, status)
//
// One request per cycle unless stalled; cells from the slot on shift on accept.
// The result is in the output register from the cycle after the transfer.
// The read path is a one-hot AND-OR across the CAPACITY cells.
// Reset clears the count and the output valid; entries need no clearing.
// in_stall is high only while a result waits and out_stall is high.
`default_nettype none

module positional_list_store
  import pls_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_stall,
  input  wire pls_in_t in_data,
  output logic         out_valid,
  input  wire          out_stall,
  output pls_out_t     out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  pls_out_t                 out_data_r;
  pls_out_t                 out_data_nxt;

  logic                     acc;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;
  logic [CMP_W-1:0]         pos_m1;
  logic                     pos_bad_rd;
  logic                     pos_bad_ins;
  logic                     do_ins;
  logic                     do_rem;
  logic                     rd_en;
  logic [ST_W-1:0]          st;
  logic [IDX_W-1:0]         idx;
  pls_cell_ctl_t            ctl;
  logic signed [DATA_W-1:0] rd_sel;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd   [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    pos_x       = CMP_W'(in_data.position);
    cnt_x       = CMP_W'(cnt_r);
    pos_m1      = pos_x - CMP_W'(1);
    pos_bad_rd  = (pos_x == '0) || (pos_x > cnt_x);
    pos_bad_ins = (pos_x == '0) || (pos_x > (cnt_x + CMP_W'(1)));
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    rd_en       = 1'b0;
    st          = ST_OK;
    idx         = pos_m1[IDX_W-1:0];
    unique case (in_data.req_type)
      REQ_INSERT: begin
        if (cnt_x >= CAP_X) begin
          st = ST_FULL;
        end else if (cnt_x == '0) begin
          do_ins = 1'b1;
          idx    = '0;
        end else if (pos_bad_ins) begin
          st = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_bad_rd) begin
          st = ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_bad_rd) begin
          st = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  assign ctl.ins   = acc && do_ins;
  assign ctl.rem   = acc && do_rem;
  assign ctl.value = in_data.value;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = in_data.value;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    pls_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .idx_i   (idx),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_data_nxt.read_value  = rd_en ? rd_sel : '0;
    out_data_nxt.entry_count = CNT_OUT_W'(cnt_nxt);
    out_data_nxt.status      = st;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= CAP_X)
    else $error("entry count above capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_rem_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("remove did not shrink the count");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> CMP_W'(cnt_r) == CAP_X)
    else $error("full status with room left");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |-> out_data_r.read_value == '0)
    else $error("failed request returned data");
`endif

endmodule

`default_nettype wire

// File: src/pls_cell.sv
// pls_cell: one storage cell of the list chain.
// Holds one entry; on insert takes the new value at the position or its left
// neighbor past it, on remove its right neighbor. Depends on pls_pkg.
`default_nettype none

module pls_cell
  import pls_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  wire                            clk,
  input  wire pls_cell_ctl_t             ctl_i,
  input  wire logic [IDX_W-1:0]          idx_i,
  input  wire logic signed [DATA_W-1:0]  left_i,
  input  wire logic signed [DATA_W-1:0]  right_i,
  output logic signed [DATA_W-1:0]       data_o,
  output logic signed [DATA_W-1:0]       rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     hit;
  logic                     after;

  assign hit   = (MY_IDX == idx_i);
  assign after = (MY_IDX > idx_i);

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins && after) begin
      data_nxt = left_i;
    end else if (ctl_i.ins && hit) begin
      data_nxt = ctl_i.value;
    end else if (ctl_i.rem && (after || hit)) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = hit ? data_r : '0;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for positional_list_store.
// Drives insert/remove/read requests with random gaps and stalls and checks each
// result against a local model of the list. Depends on pls_pkg and the DUT.

module tb_top;
  import pls_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 525;
  localparam int MAX_WAIT = 12;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int BIAS_GROW   = 0;
  localparam int BIAS_MIXED  = 1;
  localparam int BIAS_SHRINK = 2;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pls_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pls_out_t out_data;

  // list model
  logic [DATA_W-1:0] list_vals [LIST_DEPTH];
  int                list_len = 0;
  int                peak_len = 0;
  int                full_rejects = 0;
  int                range_rejects = 0;

  pls_out_t pending_results[$];
  int       mismatches = 0;
  int       requests_sent = 0;
  int       results_checked = 0;
  int       op_counts [4] = '{0, 0, 0, 0};
  bit       quiet = 1'b0;
  int       stall_left = 0;
  int       stall_mark = 0;

  positional_list_store #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic pls_out_t apply_request(pls_in_t req);
    pls_out_t res;
    int       p;
    res.read_value = '0;
    res.status = ST_OK;
    p = req.position;
    case (req.req_type)
      REQ_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (list_len == 0) begin
          list_vals[0] = req.value;
          list_len = 1;
        end else if (p == 0 || p > list_len + 1) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = list_len; i > p - 1; i--) list_vals[i] = list_vals[i-1];
          list_vals[p-1] = req.value;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        if (p == 0 || p > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      REQ_READ: begin
        if (p == 0 || p > list_len) res.status = ST_RANGE;
        else res.read_value = list_vals[p-1];
      end
      default: res.status = ST_RANGE;
    endcase
    res.entry_count = list_len[CNT_OUT_W-1:0];
    if (list_len > peak_len) peak_len = list_len;
    if (res.status == ST_FULL) full_rejects++;
    if (res.status == ST_RANGE) range_rejects++;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h8000_0000;
    if (r < 16) return 32'h7FFF_FFFF;
    if (r < 20) return '0;
    if (r < 24) return '1;
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // one transfer on the request channel; entered and left just after a falling edge
  task automatic send_req(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] val);
    int      gap;
    pls_in_t req;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    req.req_type = kind;
    req.position = pos;
    req.value = val;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(req));
    requests_sent++;
    op_counts[kind]++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_item(int bias);
    int               r;
    int               ins_pct;
    int               rem_pct;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_req(REQ_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)), $urandom);
      return;
    end
    case (bias)
      BIAS_GROW:   begin ins_pct = 75; rem_pct = 10; end
      BIAS_SHRINK: begin ins_pct = 15; rem_pct = 65; end
      default:     begin ins_pct = 40; rem_pct = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      kind = REQ_INSERT;
      if (list_len == 0) pos = POS_W'($urandom_range(0, 127));
      else pos = POS_W'($urandom_range(1, list_len + 1));
    end else begin
      kind = (r < ins_pct + rem_pct) ? REQ_REMOVE : REQ_READ;
      if (list_len == 0) pos = POS_W'($urandom_range(0, 2));
      else pos = POS_W'($urandom_range(1, list_len));
    end
    send_req(kind, pos, pick_value());
  endtask

  task automatic test_empty_store();
    send_req(REQ_READ, 7'd1, '0);
    send_req(REQ_REMOVE, 7'd1, '0);
    send_req(REQ_READ, 7'd0, '0);
    send_req(REQ_INSERT, 7'd0, 32'h8000_0000);
    send_req(REQ_REMOVE, 7'd1, '0);
    send_req(REQ_INSERT, 7'd127, 32'h7FFF_FFFF);
    send_req(REQ_READ, 7'd1, '0);
    send_req(REQ_REMOVE, 7'd1, '0);
    send_req(REQ_INSERT, 7'd64, 32'h0000_0000);
    wait_all_results();
  endtask

  task automatic test_edit_positions();
    send_req(REQ_INSERT, 7'd0, 32'h1234_5678);
    send_req(REQ_INSERT, 7'd3, 32'h1234_5678);
    send_req(REQ_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 7'd1, 32'h5555_5555);
    send_req(REQ_INSERT, 7'd2, 32'hAAAA_AAAA);
    for (int p = 1; p <= 5; p++) send_req(REQ_READ, POS_W'(p), $urandom);
    send_req(REQ_UNUSED, 7'd1, $urandom);
    send_req(REQ_REMOVE, POS_W'(list_len), '0);
    send_req(REQ_REMOVE, POS_W'(list_len + 1), '0);
    send_req(REQ_REMOVE, 7'd0, '0);
    send_req(REQ_REMOVE, 7'd2, '0);
    wait_all_results();
  endtask

  task automatic test_full_store();
    quiet = 1'b1;
    while (list_len < LIST_DEPTH / 2)
      send_req(REQ_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
    quiet = 1'b0;
    while (list_len < LIST_DEPTH)
      send_req(REQ_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
    send_req(REQ_INSERT, 7'd0, $urandom);
    send_req(REQ_INSERT, 7'd65, $urandom);
    send_req(REQ_INSERT, 7'd1, $urandom);
    send_req(REQ_READ, POS_W'(LIST_DEPTH), '0);
    send_req(REQ_READ, POS_W'(LIST_DEPTH + 1), '0);
    send_req(REQ_REMOVE, POS_W'(LIST_DEPTH), '0);
    send_req(REQ_INSERT, POS_W'(LIST_DEPTH), 32'h7FFF_FFFF);
    send_req(REQ_READ, 7'd127, '0);
    while (list_len > 0) begin
      send_req(REQ_READ, POS_W'($urandom_range(1, list_len)), '0);
      send_req(REQ_REMOVE, POS_W'($urandom_range(1, list_len)), '0);
    end
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase;
    int phase_len;
    int bias;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0:       bias = BIAS_GROW;
        2:       bias = BIAS_SHRINK;
        default: bias = BIAS_MIXED;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 90);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_random_item(bias);
        sent++;
      end
      if (phase == 3) wait_all_results();
      phase++;
    end
    quiet = 1'b0;
    wait_all_results();
  endtask

  // result checking
  always @(posedge clk) begin
    pls_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_data.entry_count, want.entry_count);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
      results_checked++;
    end
  end

  // result-side stall, drawn once per transfer
  always @(negedge clk) begin
    if (results_checked != stall_mark) begin
      stall_mark = results_checked;
      stall_left = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_empty_store();
    test_edit_positions();
    test_full_store();
    test_random_traffic();
    repeat (8) @(negedge clk);
    $display("Covered %0d requests (insert %0d, remove %0d, read %0d, unused %0d), %0d results",
             requests_sent, op_counts[REQ_INSERT], op_counts[REQ_REMOVE],
             op_counts[REQ_READ], op_counts[REQ_UNUSED], results_checked);
    $display("Peak size %0d of %0d, %0d full-store rejects, %0d bad-position rejects",
             peak_len, LIST_DEPTH, full_rejects, range_rejects);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
src/pls_pkg.sv
src/pls_cell.sv
src/positional_list_store.sv
tb/sv/tb_top.sv
